FILE: hdl/assert_macros.svh
// Assertion macros shared by the shape fill engine modules.
// Depends on nothing; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define BSFE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BSFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BSFE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BSFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/bsfe_pkg.sv
// Shared types and constants of the bitmap shape fill engine.
// Used by the front, queue, back and top-level modules; depends on nothing.
package bsfe_pkg;

  localparam int CANVAS_SIZE_DEF = 64;
  localparam int QUEUE_DEPTH     = 4;
  localparam int DIM_W           = 7;
  localparam int DIM_RESET       = 64;
  localparam int ROW_W           = 64;
  localparam int POS_W           = 9;
  localparam int CFG_IDX_W       = 1;
  localparam int IN_TDATA_W      = 40;
  localparam int IN_TUSER_W      = 2;
  localparam int OUT_TDATA_W     = 64;
  localparam int OUT_TUSER_W     = 1;

  typedef enum logic [1:0] {
    ACT_SQUARE,
    ACT_TRIANGLE,
    ACT_LINE,
    ACT_READ
  } action_t;

  typedef enum logic [1:0] {
    DIR_RD,
    DIR_RU,
    DIR_LD,
    DIR_LU
  } corner_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT
  } cfg_reg_t;

  // One classified command: a run of row spans walked one row per step.
  typedef struct packed {
    logic                    err;
    logic                    rd;
    logic signed [POS_W-1:0] row;
    logic [DIM_W-1:0]        col;
    logic [DIM_W-1:0]        len;
    logic [DIM_W-1:0]        count;
    logic                    row_dn;
    logic                    col_up;
    logic                    col_dn;
    logic                    len_up;
    logic                    len_dn;
    logic [DIM_W-1:0]        row_lim;
  } job_t;

endpackage

FILE: hdl/bitmap_shape_fill_engine.sv
// Top level of the bitmap shape fill engine.
// Depends on bsfe_pkg, bsfe_front, bsfe_queue and bsfe_back.
//
// Commands enter on the s_ stream: s_tuser is the action (square, triangle,
// line, read row), s_tdata the shape operands. Each request gives exactly one
// result on the m_ stream: m_tuser is the status (set when the bounds check
// failed and nothing was drawn), m_tdata the read row masked to the canvas
// width, zero for drawing commands. Write width (index 0) and height (index 1)
// on the cfg_ channel only while the block is idle; cfg_ready is always high.
//
// The back end walks one canvas row per cycle, unless a held result stalls it,
// through a read-modify-write pipeline, so a request holds it max(1, n) steps:
// n is the size of a square or triangle, |dy|+1 of a vertical line, |dx|+1 of
// a diagonal; a horizontal line, a row read or a rejected request takes one.
// m_tvalid is set in the result register once the last step leaves the write
// stage. A short job queue keeps the front accepting while the back end draws.
// Reset (synchronous rst) clears the queue, the pipeline and the row valid
// bits, so the canvas reads as zero at once; width and height return to 64.
// When m_tready is low the result holds, the back end stalls behind it, and
// the queue absorbs requests until it fills and s_tready drops.
module bitmap_shape_fill_engine #(
  parameter int CANVAS_SIZE = bsfe_pkg::CANVAS_SIZE_DEF,
  parameter int QUEUE_DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // cfg_index: register index; cfg_data: register value.
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bsfe_pkg::DIM_W-1:0]       cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // s_tdata, low bit up: x_pos[6:0], y_pos[13:7], size[20:14], direction[22:21],
  // x_end[29:23], y_end[36:30], zero pad [39:37].
  input  logic [bsfe_pkg::IN_TDATA_W-1:0]  s_tdata,
  // s_tuser: action[1:0].
  input  logic [bsfe_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // m_tdata: row_bits[63:0].
  output logic [bsfe_pkg::OUT_TDATA_W-1:0] m_tdata,
  // m_tuser: status[0].
  output logic [bsfe_pkg::OUT_TUSER_W-1:0] m_tuser
);

  // Request handoff from front to queue, and from queue to back end.
  logic           push, queue_full;
  logic           pop, job_valid;
  bsfe_pkg::job_t front_job, queue_job;

  // Hold config and classify each request into a row walk.
  bsfe_front #(
    .CANVAS_SIZE(CANVAS_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .queue_full (queue_full),
    .push       (push),
    .job        (front_job)
  );

  // Buffer classified requests so each side stalls on its own.
  bsfe_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_job    (front_job),
    .full      (queue_full),
    .pop       (pop),
    .out_valid (job_valid),
    .out_job   (queue_job)
  );

  // Draw into the canvas memory and deliver one result per request.
  bsfe_back #(
    .CANVAS_SIZE(CANVAS_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (queue_job),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

FILE: hdl/bsfe_front.sv
// Front end: configuration registers, bounds checks and command classification.
// Depends on bsfe_pkg.
module bsfe_front #(
  parameter int CANVAS_SIZE = bsfe_pkg::CANVAS_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsfe_pkg::DIM_W-1:0]        cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bsfe_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic [bsfe_pkg::IN_TUSER_W-1:0]   s_tuser,
  input  logic                              queue_full,
  output logic                              push,
  output bsfe_pkg::job_t                    job
);

  localparam int DW = bsfe_pkg::DIM_W;
  localparam int PW = bsfe_pkg::POS_W;
  localparam logic [DW-1:0] CS = DW'(CANVAS_SIZE);

  logic [DW-1:0] canvas_width;
  logic [DW-1:0] canvas_height;

  logic [DW-1:0] w_eff, h_eff;
  logic [DW-1:0] x, y, s, xe, ye;
  bsfe_pkg::action_t act;
  bsfe_pkg::corner_t corner;
  logic [DW:0]   x_sum, y_sum;
  logic          fit_x_pos, fit_y_pos, fit_x_neg, fit_y_neg;
  logic [DW-1:0] cnt_s, len_one, col_ld;
  logic [PW-1:0] row_up;
  logic          line_err;
  logic [DW-1:0] lo_x, hi_x, lo_y, hi_y, xl, yl, yr;
  bsfe_pkg::job_t j;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= DW'(bsfe_pkg::DIM_RESET);
      canvas_height <= DW'(bsfe_pkg::DIM_RESET);
    end else if (cfg_valid) begin
      case (bsfe_pkg::cfg_reg_t'(cfg_index))
        bsfe_pkg::REG_WIDTH:  canvas_width  <= cfg_data;
        bsfe_pkg::REG_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the configured dimensions to the physical canvas.
  assign w_eff = (canvas_width  > CS) ? CS : canvas_width;
  assign h_eff = (canvas_height > CS) ? CS : canvas_height;

  assign act    = bsfe_pkg::action_t'(s_tuser);
  assign x      = s_tdata[6:0];
  assign y      = s_tdata[13:7];
  assign s      = s_tdata[20:14];
  assign corner = bsfe_pkg::corner_t'(s_tdata[22:21]);
  assign xe     = s_tdata[29:23];
  assign ye     = s_tdata[36:30];

  assign x_sum     = {1'b0, x} + {1'b0, s};
  assign y_sum     = {1'b0, y} + {1'b0, s};
  assign fit_x_pos = x_sum <= {1'b0, w_eff};
  assign fit_y_pos = y_sum <= {1'b0, h_eff};
  assign fit_x_neg = (s <= x) && (x < w_eff);
  assign fit_y_neg = (s <= y) && (y < h_eff);

  assign cnt_s   = (s == '0) ? DW'(1) : s;
  assign len_one = (s == '0) ? '0 : DW'(1);
  assign col_ld  = x - s + DW'(1);
  assign row_up  = PW'(y) - PW'(s) + PW'(1);

  assign line_err = (x >= w_eff) || (y >= h_eff) || (xe >= w_eff) || (ye >= h_eff);
  assign lo_x = (x < xe) ? x : xe;
  assign hi_x = (x < xe) ? xe : x;
  assign lo_y = (y < ye) ? y : ye;
  assign hi_y = (y < ye) ? ye : y;
  assign xl   = (x < xe) ? x : xe;
  assign yl   = (x < xe) ? y : ye;
  assign yr   = (x < xe) ? ye : y;

  always_comb begin
    j         = '0;
    j.count   = DW'(1);
    j.row_lim = h_eff;
    case (act)
      bsfe_pkg::ACT_SQUARE: begin
        j.err   = !(fit_x_pos && fit_y_pos);
        j.row   = PW'(y);
        j.col   = x;
        j.len   = s;
        j.count = cnt_s;
      end
      bsfe_pkg::ACT_TRIANGLE: begin
        j.count = cnt_s;
        case (corner)
          bsfe_pkg::DIR_RD: begin
            j.err    = !(fit_x_pos && fit_y_pos);
            j.row    = PW'(y);
            j.col    = x;
            j.len    = s;
            j.len_dn = 1'b1;
          end
          bsfe_pkg::DIR_RU: begin
            j.err    = !(fit_x_pos && fit_y_neg);
            j.row    = row_up;
            j.col    = x;
            j.len    = len_one;
            j.len_up = 1'b1;
          end
          bsfe_pkg::DIR_LD: begin
            j.err    = !(fit_x_neg && fit_y_pos);
            j.row    = PW'(y);
            j.col    = col_ld;
            j.col_up = 1'b1;
            j.len    = s;
            j.len_dn = 1'b1;
          end
          bsfe_pkg::DIR_LU: begin
            j.err    = !(fit_x_neg && fit_y_neg);
            j.row    = row_up;
            j.col    = x;
            j.col_dn = 1'b1;
            j.len    = len_one;
            j.len_up = 1'b1;
          end
          default: ;
        endcase
      end
      bsfe_pkg::ACT_LINE: begin
        j.err = line_err;
        if (x == xe) begin
          j.row   = PW'(lo_y);
          j.col   = x;
          j.len   = DW'(1);
          j.count = hi_y - lo_y + DW'(1);
        end else if (y == ye) begin
          j.row = PW'(y);
          j.col = lo_x;
          j.len = hi_x - lo_x + DW'(1);
        end else begin
          j.row    = PW'(yl);
          j.col    = xl;
          j.len    = DW'(1);
          j.col_up = 1'b1;
          j.row_dn = yr < yl;
          j.count  = hi_x - lo_x + DW'(1);
        end
      end
      bsfe_pkg::ACT_READ: begin
        j.err = !(y < h_eff);
        j.rd  = y < h_eff;
        j.row = PW'(y);
        j.len = w_eff;
      end
      default: ;
    endcase
    // A rejected command still takes one step so that it reports.
    if (j.err) begin
      j.count = DW'(1);
    end
  end

  assign job      = j;
  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

endmodule

FILE: hdl/bsfe_queue.sv
// Short job queue between the front end and the drawing back end.
// Depends on bsfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsfe_queue #(
  parameter int DEPTH = bsfe_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bsfe_pkg::job_t in_job,
  output logic           full,
  input  logic           pop,
  output logic           out_valid,
  output bsfe_pkg::job_t out_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bsfe_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_job;
    end
  end

  assign full      = fill == CNT_W'(DEPTH);
  assign out_valid = fill != '0;
  assign out_job   = slots[rd_ptr];

  `BSFE_ASSERT_IMPL(a_no_overflow, clk, rst, push, !full, "job queue written while full")
  `BSFE_ASSERT_IMPL(a_no_underflow, clk, rst, pop, out_valid, "job queue read while empty")

endmodule

FILE: hdl/bsfe_back.sv
// Back end: walks each job one canvas row per cycle, unless a held result stalls
// it, with a read-modify-write pipeline on the canvas memory, and holds the
// result register. Depends on bsfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bsfe_back #(
  parameter int CANVAS_SIZE = bsfe_pkg::CANVAS_SIZE_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             job_valid,
  input  bsfe_pkg::job_t                   job,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [bsfe_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [bsfe_pkg::OUT_TUSER_W-1:0] m_tuser
);

  localparam int AW = $clog2(CANVAS_SIZE);
  localparam int DW = bsfe_pkg::DIM_W;
  localparam int PW = bsfe_pkg::POS_W;
  localparam int RW = bsfe_pkg::ROW_W;

  logic [RW-1:0] canvas [CANVAS_SIZE];
  logic [CANVAS_SIZE-1:0] row_vld;

  // Step generator.
  logic           active;
  bsfe_pkg::job_t cur;
  logic [DW-1:0]  k;
  logic           gen_last;
  logic [RW-1:0]  a_mask;
  logic           a_in_rows, a_we;
  logic [AW-1:0]  a_addr;

  // Write stage.
  logic          b_valid, b_last, b_we, b_rd, b_err, b_byp, b_vld;
  logic [AW-1:0] b_row;
  logic [RW-1:0] b_mask, b_byp_data, rd_raw, b_cur, b_wdata;

  logic          adv;
  logic          out_status;
  logic [RW-1:0] out_bits;

  assign gen_last  = (k + DW'(1)) == cur.count;
  assign a_mask    = (~({RW{1'b1}} << cur.len)) << cur.col;
  assign a_in_rows = !cur.row[PW-1] && (cur.row[PW-2:0] < (PW-1)'(cur.row_lim));
  assign a_we      = !cur.err && !cur.rd && a_in_rows;
  assign a_addr    = cur.row[AW-1:0];

  // Stall everything only when a finished result cannot be parked.
  assign adv = !b_valid || !b_last || !m_tvalid || m_tready;
  assign pop = job_valid && (!active || (adv && gen_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
    end else if (pop) begin
      active <= 1'b1;
      k      <= '0;
    end else if (adv && active) begin
      if (gen_last) begin
        active <= 1'b0;
      end else begin
        k <= k + DW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= job;
    end else if (adv && active) begin
      cur.row <= cur.row_dn ? cur.row - PW'(1) : cur.row + PW'(1);
      if (cur.col_up) begin
        cur.col <= cur.col + DW'(1);
      end else if (cur.col_dn) begin
        cur.col <= cur.col - DW'(1);
      end
      if (cur.len_up) begin
        cur.len <= cur.len + DW'(1);
      end else if (cur.len_dn) begin
        cur.len <= cur.len - DW'(1);
      end
    end
  end

  assign b_cur   = b_byp ? b_byp_data : (b_vld ? rd_raw : '0);
  assign b_wdata = b_cur | b_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_last     <= gen_last;
      b_we       <= a_we;
      b_rd       <= cur.rd;
      b_err      <= cur.err;
      b_row      <= a_addr;
      b_mask     <= a_mask;
      b_byp      <= b_valid && b_we && (b_row == a_addr);
      b_byp_data <= b_wdata;
      b_vld      <= row_vld[a_addr];
      rd_raw     <= canvas[a_addr];
      if (b_valid && b_we) begin
        canvas[b_row] <= b_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
    end else if (adv && b_valid && b_we) begin
      row_vld[b_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv && b_valid && b_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid && b_last) begin
      out_status <= b_err;
      out_bits   <= b_rd ? (b_cur & b_mask) : '0;
    end
  end

  assign m_tdata = out_bits;
  assign m_tuser = out_status;

  `BSFE_ASSERT_IMPL(a_write_clean, clk, rst, b_valid && b_we, !b_err && !b_rd, "write from a rejected or read job")
  `BSFE_ASSERT_IMPL(a_read_single, clk, rst, b_valid && b_rd, b_last, "read job took more than one step")
  `BSFE_ASSERT_IMPL(a_step_bound, clk, rst, active, k < cur.count, "step index ran past job length")
  `BSFE_ASSERT_NEXT(a_pop_starts, clk, rst, pop, active, "popped job did not start")

endmodule
